/* sv/vpc_pkg.sv */
// vpc_pkg: shared constants, types and the arctangent table for vector_polar_convert.
// Used by vpc_cell, vector_polar_convert, vpc_check and tb_top. No dependencies.

package vpc_pkg;

	localparam int ROTATION_STEPS = 24;
	localparam int STEP_W = (ROTATION_STEPS > 1) ? $clog2(ROTATION_STEPS) : 1;
	localparam int DW = 44;
	localparam int ZW = 34;
	localparam int GUARD_BITS = 8;
	localparam int LATENCY = 2 * ROTATION_STEPS + 5;

	localparam longint unsigned GAIN_BASE = 64'd2608131496;
	localparam longint unsigned GAIN_TAIL = 64'd1738754331;
	localparam longint unsigned GAIN_FULL = GAIN_BASE +
		((2 * ROTATION_STEPS < 32) ? (GAIN_TAIL >> (2 * ROTATION_STEPS)) : 64'd0);
	localparam logic [31:0] GAIN_Q32 = GAIN_FULL[31:0];

	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

	localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] SAT_MIN = -32'sh7FFF_FFFF - 32'sd1;

	localparam logic [31:0] ATAN_TABLE [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef enum logic [1:0] {
		CMD_QUERY      = 2'd0,
		CMD_SET_LENGTH = 2'd1,
		CMD_SET_TURN   = 2'd2
	} cmd_t;

	// side data that travels with an item down both chains
	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic [30:0]        length_in;
		logic [31:0]        turn_in;
		logic               special;
		logic [31:0]        turn_res;
		logic [31:0]        len_res;
		logic               flip;
	} item_t;

	function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
		return ATAN_TABLE[5'(idx)];
	endfunction

endpackage

/* sv/vpc_cell.sv */
// vpc_cell: one CORDIC micro-rotation stage, vectoring or rotation mode.
// Depends on vpc_pkg.

module vpc_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             vectoring,
	input  logic [vpc_pkg::STEP_W-1:0]       step,
	input  logic                             in_valid,
	input  logic signed [vpc_pkg::DW-1:0]    in_vx,
	input  logic signed [vpc_pkg::DW-1:0]    in_vy,
	input  logic signed [vpc_pkg::ZW-1:0]    in_z,
	input  vpc_pkg::item_t                   in_item,
	output logic                             out_valid,
	output logic signed [vpc_pkg::DW-1:0]    out_vx,
	output logic signed [vpc_pkg::DW-1:0]    out_vy,
	output logic signed [vpc_pkg::ZW-1:0]    out_z,
	output vpc_pkg::item_t                   out_item
);

	logic                          cw;
	logic signed [vpc_pkg::DW-1:0] sx, sy;
	logic signed [vpc_pkg::ZW-1:0] ang;
	logic                          valid_q;
	logic signed [vpc_pkg::DW-1:0] vx_q, vy_q;
	logic signed [vpc_pkg::ZW-1:0] z_q;
	vpc_pkg::item_t                item_q;

	// clockwise: vectoring drives y to zero, rotation drives z to zero
	assign cw = vectoring ? !in_vy[vpc_pkg::DW-1] : in_z[vpc_pkg::ZW-1];
	assign sx = in_vx >>> step;
	assign sy = in_vy >>> step;
	assign ang = signed'(vpc_pkg::ZW'(vpc_pkg::atan_turn(step)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cw) begin
			vx_q <= in_vx + sy;
			vy_q <= in_vy - sx;
			z_q  <= in_z + ang;
		end else begin
			vx_q <= in_vx - sy;
			vy_q <= in_vy + sx;
			z_q  <= in_z - ang;
		end
		item_q <= in_item;
	end

	assign out_valid = valid_q;
	assign out_vx    = vx_q;
	assign out_vy    = vy_q;
	assign out_z     = z_q;
	assign out_item  = item_q;

endmodule

/* sv/vector_polar_convert.sv */
// vector_polar_convert: Cartesian to polar and back for Q16.16 vectors, CORDIC chains.
// Depends on vpc_pkg and vpc_cell.

// One item enters per clock: busy is always low and start may be high every cycle.
// Each item's result is on done for one cycle, in order, one result per item. On its way
// the item passes the input stage, a chain of ROTATION_STEPS vectoring CORDIC cells, two
// gain-multiply stages, the rotation setup, a chain of ROTATION_STEPS rotation CORDIC cells
// and the output register. Results are not held: the receiver must take each one
// in its done cycle.

module vector_polar_convert (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	input  logic [30:0]        length_in,
	input  logic [31:0]        turn_in,
	output logic               done,
	output logic [31:0]        turn_out,
	output logic [31:0]        length_out,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic               saturated
);

	// input stage
	logic                          accept;
	logic signed [vpc_pkg::DW-1:0] x_ext, y_ext, x_abs, y_abs, vx_init, vy_init;
	logic                          x_neg;
	vpc_pkg::item_t                item_init;

	logic                          valid_s1;
	logic signed [vpc_pkg::DW-1:0] vx_s1, vy_s1;
	logic signed [vpc_pkg::ZW-1:0] z_s1;
	vpc_pkg::item_t                item_s1;

	// vectoring chain
	logic                          vv_valid [vpc_pkg::ROTATION_STEPS+1];
	logic signed [vpc_pkg::DW-1:0] vv_vx    [vpc_pkg::ROTATION_STEPS+1];
	logic signed [vpc_pkg::DW-1:0] vv_vy    [vpc_pkg::ROTATION_STEPS+1];
	logic signed [vpc_pkg::ZW-1:0] vv_z     [vpc_pkg::ROTATION_STEPS+1];
	vpc_pkg::item_t                vv_item  [vpc_pkg::ROTATION_STEPS+1];

	// gain multiply
	logic [vpc_pkg::DW-2:0]        mag_u;
	logic                          valid_s2;
	logic [vpc_pkg::DW-2-32+32:0]  hi_s2;
	logic [63:0]                   lo_s2;
	logic [31:0]                   turn_s2;
	vpc_pkg::item_t                item_s2;

	logic [vpc_pkg::DW:0]          len_sum;
	logic [vpc_pkg::DW-8:0]        len_rnd;
	logic [31:0]                   len_sat;
	logic                          valid_s3;
	vpc_pkg::item_t                item_s3_d;
	vpc_pkg::item_t                item_s3;

	// rotation setup
	logic [31:0]                   tgt_turn, tgt_mag, tgt_fold;
	logic                          tgt_flip;
	logic                          valid_s4;
	logic [63:0]                   prod_s4;
	logic signed [vpc_pkg::ZW-1:0] z_s4;
	vpc_pkg::item_t                item_s4_d;
	vpc_pkg::item_t                item_s4;

	// rotation chain
	logic                          rv_valid [vpc_pkg::ROTATION_STEPS+1];
	logic signed [vpc_pkg::DW-1:0] rv_vx    [vpc_pkg::ROTATION_STEPS+1];
	logic signed [vpc_pkg::DW-1:0] rv_vy    [vpc_pkg::ROTATION_STEPS+1];
	logic signed [vpc_pkg::ZW-1:0] rv_z     [vpc_pkg::ROTATION_STEPS+1];
	vpc_pkg::item_t                rv_item  [vpc_pkg::ROTATION_STEPS+1];

	// output stage
	vpc_pkg::item_t                item_f;
	logic signed [vpc_pkg::DW-1:0] fx, fy, rx, ry;
	logic                          sat_x, sat_y;
	logic signed [31:0]            cx, cy, sel_x, sel_y;
	logic                          sel_sat;
	logic                          done_q;
	logic [31:0]                   turn_s5, len_s5;
	logic signed [31:0]            x_s5, y_s5;
	logic                          sat_s5;

	localparam logic signed [vpc_pkg::DW-1:0] MAX_EXT = vpc_pkg::DW'(vpc_pkg::SAT_MAX);
	localparam logic signed [vpc_pkg::DW-1:0] MIN_EXT = vpc_pkg::DW'(vpc_pkg::SAT_MIN);
	localparam logic signed [vpc_pkg::DW-1:0] RND = vpc_pkg::DW'(1 << (vpc_pkg::GUARD_BITS-1));

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// input stage: fold left half plane, flag zero and on-axis vectors
	assign x_ext = vpc_pkg::DW'(x_in);
	assign y_ext = vpc_pkg::DW'(y_in);
	assign x_neg = x_in[31];
	assign x_abs = x_neg ? -x_ext : x_ext;
	assign y_abs = y_in[31] ? -y_ext : y_ext;
	assign vx_init = (x_neg ? -x_ext : x_ext) <<< vpc_pkg::GUARD_BITS;
	assign vy_init = (x_neg ? -y_ext : y_ext) <<< vpc_pkg::GUARD_BITS;

	always_comb begin
		item_init.cmd       = vpc_pkg::cmd_t'(command);
		item_init.x_in      = x_in;
		item_init.y_in      = y_in;
		item_init.length_in = length_in;
		item_init.turn_in   = turn_in;
		item_init.special   = (x_in == 32'sd0) || (y_in == 32'sd0);
		item_init.flip      = 1'b0;
		if (x_in == 32'sd0 && y_in == 32'sd0) begin
			item_init.turn_res = '0;
			item_init.len_res  = '0;
		end else if (y_in == 32'sd0) begin
			item_init.turn_res = x_neg ? vpc_pkg::HALF_TURN : '0;
			item_init.len_res  = x_abs[31:0];
		end else if (x_in == 32'sd0) begin
			item_init.turn_res = y_in[31] ? vpc_pkg::THREE_QUARTER_TURN : vpc_pkg::QUARTER_TURN;
			item_init.len_res  = y_abs[31:0];
		end else begin
			item_init.turn_res = '0;
			item_init.len_res  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= vv_valid[vpc_pkg::ROTATION_STEPS];
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			done_q   <= rv_valid[vpc_pkg::ROTATION_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		vx_s1   <= vx_init;
		vy_s1   <= vy_init;
		z_s1    <= x_neg ? vpc_pkg::ZW'(vpc_pkg::HALF_TURN) : '0;
		item_s1 <= item_init;
	end

	assign vv_valid[0] = valid_s1;
	assign vv_vx[0]    = vx_s1;
	assign vv_vy[0]    = vy_s1;
	assign vv_z[0]     = z_s1;
	assign vv_item[0]  = item_s1;

	for (genvar g = 0; g < vpc_pkg::ROTATION_STEPS; g++) begin : g_vec
		vpc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.vectoring (1'b1),
			.step      (vpc_pkg::STEP_W'(g)),
			.in_valid  (vv_valid[g]),
			.in_vx     (vv_vx[g]),
			.in_vy     (vv_vy[g]),
			.in_z      (vv_z[g]),
			.in_item   (vv_item[g]),
			.out_valid (vv_valid[g+1]),
			.out_vx    (vv_vx[g+1]),
			.out_vy    (vv_vy[g+1]),
			.out_z     (vv_z[g+1]),
			.out_item  (vv_item[g+1])
		);
	end

	// length = x * K / 2^32, split into high and low partial products
	assign mag_u = vv_vx[vpc_pkg::ROTATION_STEPS][vpc_pkg::DW-1] ? '0 :
		vv_vx[vpc_pkg::ROTATION_STEPS][vpc_pkg::DW-2:0];

	always_ff @(posedge clk) begin
		hi_s2   <= mag_u[vpc_pkg::DW-2:32] * vpc_pkg::GAIN_Q32;
		lo_s2   <= mag_u[31:0] * vpc_pkg::GAIN_Q32;
		turn_s2 <= vv_z[vpc_pkg::ROTATION_STEPS][31:0];
		item_s2 <= vv_item[vpc_pkg::ROTATION_STEPS];
	end

	assign len_sum = (vpc_pkg::DW+1)'(hi_s2) + (vpc_pkg::DW+1)'(lo_s2[63:32]);
	assign len_rnd = (vpc_pkg::DW-7)'((len_sum + (vpc_pkg::DW+1)'(128)) >> vpc_pkg::GUARD_BITS);
	assign len_sat = (len_rnd > (vpc_pkg::DW-7)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len_rnd[31:0];

	always_comb begin
		item_s3_d = item_s2;
		if (!item_s2.special) begin
			item_s3_d.turn_res = turn_s2;
			item_s3_d.len_res  = len_sat;
		end
	end

	always_ff @(posedge clk) begin
		item_s3 <= item_s3_d;
	end

	// rotation setup: pick target, fold into [-1/4, 1/4) turn, scale by K
	assign tgt_turn = (item_s3.cmd == vpc_pkg::CMD_SET_LENGTH) ? item_s3.turn_res : item_s3.turn_in;
	assign tgt_mag  = (item_s3.cmd == vpc_pkg::CMD_SET_LENGTH) ?
		{1'b0, item_s3.length_in} : item_s3.len_res;
	assign tgt_flip = ((tgt_turn + vpc_pkg::QUARTER_TURN) & vpc_pkg::HALF_TURN) != '0;
	assign tgt_fold = tgt_flip ? (tgt_turn - vpc_pkg::HALF_TURN) : tgt_turn;

	always_comb begin
		item_s4_d      = item_s3;
		item_s4_d.flip = tgt_flip;
	end

	always_ff @(posedge clk) begin
		prod_s4 <= tgt_mag * vpc_pkg::GAIN_Q32;
		z_s4    <= vpc_pkg::ZW'(signed'(tgt_fold));
		item_s4 <= item_s4_d;
	end

	assign rv_valid[0] = valid_s4;
	assign rv_vx[0]    = signed'(vpc_pkg::DW'(prod_s4[63:24]));
	assign rv_vy[0]    = '0;
	assign rv_z[0]     = z_s4;
	assign rv_item[0]  = item_s4;

	for (genvar g = 0; g < vpc_pkg::ROTATION_STEPS; g++) begin : g_rot
		vpc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.vectoring (1'b0),
			.step      (vpc_pkg::STEP_W'(g)),
			.in_valid  (rv_valid[g]),
			.in_vx     (rv_vx[g]),
			.in_vy     (rv_vy[g]),
			.in_z      (rv_z[g]),
			.in_item   (rv_item[g]),
			.out_valid (rv_valid[g+1]),
			.out_vx    (rv_vx[g+1]),
			.out_vy    (rv_vy[g+1]),
			.out_z     (rv_z[g+1]),
			.out_item  (rv_item[g+1])
		);
	end

	// output: unfold, drop guard bits with round half up, clamp
	assign item_f = rv_item[vpc_pkg::ROTATION_STEPS];
	assign fx = item_f.flip ? -rv_vx[vpc_pkg::ROTATION_STEPS] : rv_vx[vpc_pkg::ROTATION_STEPS];
	assign fy = item_f.flip ? -rv_vy[vpc_pkg::ROTATION_STEPS] : rv_vy[vpc_pkg::ROTATION_STEPS];
	assign rx = (fx + RND) >>> vpc_pkg::GUARD_BITS;
	assign ry = (fy + RND) >>> vpc_pkg::GUARD_BITS;
	assign sat_x = (rx > MAX_EXT) || (rx < MIN_EXT);
	assign sat_y = (ry > MAX_EXT) || (ry < MIN_EXT);
	assign cx = (rx > MAX_EXT) ? vpc_pkg::SAT_MAX : ((rx < MIN_EXT) ? vpc_pkg::SAT_MIN : rx[31:0]);
	assign cy = (ry > MAX_EXT) ? vpc_pkg::SAT_MAX : ((ry < MIN_EXT) ? vpc_pkg::SAT_MIN : ry[31:0]);

	always_comb begin
		case (item_f.cmd)
			vpc_pkg::CMD_SET_LENGTH, vpc_pkg::CMD_SET_TURN: begin
				sel_x   = cx;
				sel_y   = cy;
				sel_sat = sat_x || sat_y;
			end
			default: begin
				sel_x   = item_f.x_in;
				sel_y   = item_f.y_in;
				sel_sat = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		turn_s5 <= item_f.turn_res;
		len_s5  <= item_f.len_res;
		x_s5    <= sel_x;
		y_s5    <= sel_y;
		sat_s5  <= sel_sat;
	end

	assign done       = done_q;
	assign turn_out   = turn_s5;
	assign length_out = len_s5;
	assign x_out      = x_s5;
	assign y_out      = y_s5;
	assign saturated  = sat_s5;

endmodule

/* sv/vpc_check.sv */
// vpc_check: port-level checks for vector_polar_convert, bound to the top level.
// Depends on vpc_pkg.

module vpc_check (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [1:0]         command,
	input logic signed [31:0] x_in,
	input logic signed [31:0] y_in,
	input logic               done,
	input logic signed [31:0] x_out,
	input logic signed [31:0] y_out,
	input logic               saturated
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(vpc_pkg::LATENCY) done)
		else $error("item lost");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, vpc_pkg::LATENCY))
		else $error("result without item");

	a_sat_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (x_out == vpc_pkg::SAT_MAX || x_out == vpc_pkg::SAT_MIN ||
			y_out == vpc_pkg::SAT_MAX || y_out == vpc_pkg::SAT_MIN))
		else $error("saturated without clamped output");

	a_query_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && (command == vpc_pkg::CMD_QUERY || command == 2'd3),
			vpc_pkg::LATENCY)) |->
		(x_out == $past(x_in, vpc_pkg::LATENCY) && y_out == $past(y_in, vpc_pkg::LATENCY) &&
			!saturated))
		else $error("query item not passed through");

endmodule

bind vector_polar_convert vpc_check u_vpc_check (.*);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench for vector_polar_convert (Cartesian/polar CORDIC conversion).
// Holds a scoreboard class with a bit-exact predictor; depends on vpc_pkg and the RTL.

module tb_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 500;

	typedef struct packed {
		vpc_pkg::cmd_t      cmd;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        length;
		logic [31:0]        turn;
	} vec_item_t;

	typedef struct packed {
		logic [31:0]        turn;
		logic [31:0]        length;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               sat;
	} polar_result_t;

	class conversion_scoreboard;
		localparam int STEPS = (vpc_pkg::ROTATION_STEPS > 32) ? 32 : vpc_pkg::ROTATION_STEPS;
		localparam longint unsigned CORDIC_GAIN = 64'd2608131496 +
			((2 * STEPS < 32) ? (64'd1738754331 >> (2 * STEPS)) : 64'd0);

		logic [31:0] arctan_turn [32];
		polar_result_t expected_conversions [$];
		int unsigned mismatches;

		function new();
			arctan_turn = '{
				32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
				32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
				32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
				32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
				32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
				32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
				32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
				32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
			};
			mismatches = 0;
		endfunction

		function void vector_to_polar(input longint x, input longint y,
				output logic [31:0] turn, output logic [31:0] len);
			longint vx, vy, nx;
			longint unsigned u, r;
			logic [31:0] z;
			int i;
			z = '0;
			if (x == 0 && y == 0) begin
				turn = '0;
				len = '0;
				return;
			end
			if (y == 0) begin
				turn = (x > 0) ? 32'h0 : vpc_pkg::HALF_TURN;
				len = 32'((x > 0) ? x : -x);
				return;
			end
			if (x == 0) begin
				turn = (y > 0) ? vpc_pkg::QUARTER_TURN : vpc_pkg::THREE_QUARTER_TURN;
				len = 32'((y > 0) ? y : -y);
				return;
			end
			if (x < 0) begin
				x = -x;
				y = -y;
				z = vpc_pkg::HALF_TURN;
			end
			vx = x * 256;
			vy = y * 256;
			for (i = 0; i < STEPS; i++) begin
				if (vy >= 0) begin
					nx = vx + (vy >>> i);
					vy = vy - (vx >>> i);
					z = z + arctan_turn[i];
				end else begin
					nx = vx - (vy >>> i);
					vy = vy + (vx >>> i);
					z = z - arctan_turn[i];
				end
				vx = nx;
			end
			turn = z;
			if (vx < 0)
				vx = 0;
			u = vx;
			r = (u >> 32) * CORDIC_GAIN + (((u & 64'hFFFF_FFFF) * CORDIC_GAIN) >> 32);
			r = (r + 128) >> 8;
			len = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
		endfunction

		function logic signed [31:0] clamp_q16(input longint v, inout logic sat);
			if (v > 64'sd2147483647) begin
				sat = 1'b1;
				return 32'sh7FFF_FFFF;
			end
			if (v < -64'sd2147483648) begin
				sat = 1'b1;
				return 32'sh8000_0000;
			end
			return v[31:0];
		endfunction

		function void polar_to_vector(input logic [31:0] turn, input longint unsigned len,
				output logic signed [31:0] ox, output logic signed [31:0] oy,
				output logic sat);
			longint vx, vy, nx, z;
			logic [31:0] t, folded;
			logic flip;
			int i;
			t = turn;
			folded = t + vpc_pkg::QUARTER_TURN;
			flip = folded[31];
			if (flip)
				t = t - vpc_pkg::HALF_TURN;
			z = $signed(t);
			vx = longint'(((len & 64'hFFFF_FFFF) * CORDIC_GAIN) >> 24);
			vy = 0;
			for (i = 0; i < STEPS; i++) begin
				if (z >= 0) begin
					nx = vx - (vy >>> i);
					vy = vy + (vx >>> i);
					z = z - longint'(arctan_turn[i]);
				end else begin
					nx = vx + (vy >>> i);
					vy = vy - (vx >>> i);
					z = z + longint'(arctan_turn[i]);
				end
				vx = nx;
			end
			if (flip) begin
				vx = -vx;
				vy = -vy;
			end
			sat = 1'b0;
			ox = clamp_q16((vx + 128) >>> 8, sat);
			oy = clamp_q16((vy + 128) >>> 8, sat);
		endfunction

		function polar_result_t convert_vector(input vec_item_t v);
			polar_result_t res;
			logic [31:0] turn, len;
			logic signed [31:0] ox, oy;
			logic sat;
			vector_to_polar(v.x, v.y, turn, len);
			ox = v.x;
			oy = v.y;
			sat = 1'b0;
			case (v.cmd)
				vpc_pkg::CMD_SET_LENGTH: polar_to_vector(turn, v.length, ox, oy, sat);
				vpc_pkg::CMD_SET_TURN:   polar_to_vector(v.turn, len, ox, oy, sat);
				default: ;
			endcase
			res = '{turn, len, ox, oy, sat};
			return res;
		endfunction

		function void note_vector(input vec_item_t v);
			expected_conversions.push_back(convert_vector(v));
		endfunction

		function void check_result(input polar_result_t got);
			polar_result_t exp_res;
			if (expected_conversions.size() == 0) begin
				$error("result with no item waiting: turn %h length %h", got.turn, got.length);
				mismatches++;
				return;
			end
			exp_res = expected_conversions.pop_front();
			if (got.turn !== exp_res.turn) begin
				$error("turn_out: expected %h, got %h", exp_res.turn, got.turn);
				mismatches++;
			end
			if (got.length !== exp_res.length) begin
				$error("length_out: expected %h, got %h", exp_res.length, got.length);
				mismatches++;
			end
			if (got.x !== exp_res.x) begin
				$error("x_out: expected %h, got %h", exp_res.x, got.x);
				mismatches++;
			end
			if (got.y !== exp_res.y) begin
				$error("y_out: expected %h, got %h", exp_res.y, got.y);
				mismatches++;
			end
			if (got.sat !== exp_res.sat) begin
				$error("saturated: expected %b, got %b", exp_res.sat, got.sat);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected_conversions.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] command = '0;
	logic signed [31:0] x_in = '0;
	logic signed [31:0] y_in = '0;
	logic [30:0] length_in = '0;
	logic [31:0] turn_in = '0;
	logic busy, done, saturated;
	logic [31:0] turn_out, length_out;
	logic signed [31:0] x_out, y_out;

	conversion_scoreboard sb;
	int sender_idle = 0;
	int unsigned cycle_count = 0;

	vector_polar_convert dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.x_in       (x_in),
		.y_in       (y_in),
		.length_in  (length_in),
		.turn_in    (turn_in),
		.done       (done),
		.turn_out   (turn_out),
		.length_out (length_out),
		.x_out      (x_out),
		.y_out      (y_out),
		.saturated  (saturated)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{turn_out, length_out, x_out, y_out, saturated});
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic vec_item_t make_vector(vpc_pkg::cmd_t c, logic [31:0] x, logic [31:0] y,
			logic [30:0] len, logic [31:0] turn);
		vec_item_t v;
		v = '{c, x, y, len, turn};
		return v;
	endfunction

	function automatic logic [31:0] random_component(int unsigned mode);
		case (mode)
			0: return '0;
			1: return $signed($urandom_range(32'h0020_0000, 0)) - 32'sh0010_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_item_t random_vector();
		vec_item_t v;
		int unsigned shape;
		v.cmd = vpc_pkg::cmd_t'($urandom_range(2, 0));
		shape = $urandom_range(11, 0);
		case (shape)
			0: begin
				v.x = '0;
				v.y = random_component($urandom_range(2, 1));
			end
			1: begin
				v.x = random_component($urandom_range(2, 1));
				v.y = '0;
			end
			2: begin
				v.x = '0;
				v.y = '0;
			end
			3, 4, 5: begin
				v.x = random_component(1);
				v.y = random_component(1);
			end
			default: begin
				v.x = $urandom;
				v.y = $urandom;
			end
		endcase
		v.length = $urandom_range(1, 0) ? 31'($urandom) : 31'($urandom_range(32'h0040_0000, 0));
		if ($urandom_range(7, 0) == 0)
			v.turn = {2'($urandom_range(3, 0)), 30'h0} + $urandom_range(4, 0) - 32'd2;
		else
			v.turn = $urandom;
		return v;
	endfunction

	task automatic send_vector(input vec_item_t v);
		while ($urandom_range(99, 0) < sender_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= v.cmd;
		x_in <= v.x;
		y_in <= v.y;
		length_in <= v.length;
		turn_in <= v.turn;
		do
			@(posedge clk);
		while (busy);
		sb.note_vector(v);
	endtask

	initial begin
		int idle_pct [4];
		int p, n;
		idle_pct = '{0, 81, 0, 36};
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector, axes, extremes, fold boundaries, saturation
		send_vector(make_vector(vpc_pkg::CMD_QUERY, 32'h0, 32'h0, 31'h0, 32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_LENGTH, 32'h0, 32'h0, 31'h7FFF_FFFF, 32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h0, 32'h0, 31'h0, 32'h1234_5678));
		send_vector(make_vector(vpc_pkg::CMD_QUERY, 32'h0005_0000, 32'h0, 31'h0, 32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_LENGTH, 32'h8000_0000, 32'h0, 31'h0001_0000,
			32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h0, 32'h7FFF_FFFF, 31'h0,
			vpc_pkg::THREE_QUARTER_TURN));
		send_vector(make_vector(vpc_pkg::CMD_QUERY, 32'h0, 32'h8000_0000, 31'h0, 32'h0));
		send_vector(make_vector(vpc_pkg::CMD_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0, 32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h8000_0000, 32'h8000_0000, 31'h0,
			32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h8000_0000, 32'h8000_0000, 31'h0,
			32'h2000_0000));
		send_vector(make_vector(vpc_pkg::CMD_SET_LENGTH, 32'h1, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
			32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_LENGTH, 32'hFFFF_FFFF, 32'h1, 31'h0, 32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h0001_0000, 32'h0001_0000, 31'h0,
			32'h3FFF_FFFF));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h0001_0000, 32'h0001_0000, 31'h0,
			vpc_pkg::QUARTER_TURN));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h0001_0000, 32'h0001_0000, 31'h0,
			32'hBFFF_FFFF));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h0001_0000, 32'h0001_0000, 31'h0,
			32'hFFFF_FFFF));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h0001_0000, 32'h0001_0000, 31'h0,
			vpc_pkg::HALF_TURN));
		send_vector(make_vector(vpc_pkg::CMD_SET_LENGTH, 32'hFFFD_0000, 32'h0004_0000,
			31'h000A_0000, 32'h0));
		send_vector(make_vector(vpc_pkg::CMD_SET_TURN, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0,
			vpc_pkg::HALF_TURN));
		send_vector(make_vector(vpc_pkg::CMD_SET_LENGTH, 32'h7FFF_FFFF, 32'h1, 31'h7FFF_FFFF,
			32'h0));
		send_vector(make_vector(vpc_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'h8000_0000, 31'h0, 32'h0));

		for (p = 0; p < 4; p++) begin
			sender_idle = idle_pct[p];
			for (n = 0; n < RANDOM_PER_PHASE; n++)
				send_vector(random_vector());
		end
		start <= 1'b0;

		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (vpc_pkg::LATENCY + 8) @(posedge clk);

		if (sb.outstanding() != 0)
			$error("%0d results never arrived", sb.outstanding());
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
